// File: design/dacs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dacs_pkg
// Shared types and constants for the dual actuator cycle sequencer.
// ----------------------------------------------------------------------------
package dacs_pkg;

    // Default channel count and the number of channels the packed registers hold
    localparam int DEF_NUM_CHANNELS = 3;
    localparam int PACKED_CHANNELS  = 3;

    // Field widths
    localparam int CH_W      = 2;
    localparam int IR_W      = 8;
    localparam int TIME_W    = 32;
    localparam int TYPE_W    = 8;
    localparam int RND_W     = 2;
    localparam int PERIOD_W  = 8;
    localparam int OFFSET_W  = 16;
    localparam int ON_MS_W   = 18;
    localparam int LIMIT_W   = 19;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;
    localparam int PACK8_W    = 24;
    localparam int PACK16_W   = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLDS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_PERIODS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_PERIODS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSETS = 4'd3;

    // Action type codes
    localparam logic [TYPE_W-1:0] TYPE_STAGGER_A = 8'd1;
    localparam logic [TYPE_W-1:0] TYPE_STAGGER_B = 8'd2;
    localparam logic [TYPE_W-1:0] TYPE_RANDOM    = 8'd255;

    localparam int MS_PER_S = 1000;

    // Stream packing
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    // Configuration register set handed to the channel core
    typedef struct packed {
        logic [PACK8_W-1:0]  thresholds;
        logic [PACK8_W-1:0]  on_periods;
        logic [PACK8_W-1:0]  full_periods;
        logic [PACK16_W-1:0] offsets;
    } cfg_regs_t;

endpackage : dacs_pkg
`default_nettype wire

// File: design/dacs_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dacs_cfg_regs
// Configuration register file: thresholds, periods and stagger offsets.
// ----------------------------------------------------------------------------
module dacs_cfg_regs
    import dacs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_regs_t                  cfg_out
);

    cfg_regs_t regs_reg;

    // The user must issue writes only while idle; the block does not enforce this, and the port never stalls
    assign cfg_ready = 1'b1;
    assign cfg_out   = regs_reg;

    // Register write decode; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_THRESHOLDS:   regs_reg.thresholds   <= cfg_data[PACK8_W-1:0];
                CFG_ON_PERIODS:   regs_reg.on_periods   <= cfg_data[PACK8_W-1:0];
                CFG_FULL_PERIODS: regs_reg.full_periods <= cfg_data[PACK8_W-1:0];
                CFG_OFFSETS:      regs_reg.offsets      <= cfg_data[PACK16_W-1:0];
                default: ;
            endcase
        end
    end

endmodule : dacs_cfg_regs
`default_nettype wire

// File: design/dacs_chan_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dacs_chan_core
// Per-channel arm/cycle state and the single-pass update of one request.
// ----------------------------------------------------------------------------
module dacs_chan_core
    import dacs_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire logic [CH_W-1:0]   channel,
    input  wire logic [IR_W-1:0]   ir_level,
    input  wire logic [TIME_W-1:0] time_ms,
    input  wire logic [TYPE_W-1:0] requested_type,
    input  wire logic [RND_W-1:0]  random_type,
    input  wire cfg_regs_t         cfg,
    output logic                   drive_a,
    output logic                   drive_b
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic                armed_reg     [NUM_CHANNELS];
    logic                cycling_reg   [NUM_CHANNELS];
    logic [TIME_W-1:0]   start_reg     [NUM_CHANNELS];
    logic                lead_b_reg    [NUM_CHANNELS];
    logic [OFFSET_W-1:0] offset_reg    [NUM_CHANNELS];
    logic [1:0]          drive_reg     [NUM_CHANNELS];

    logic [3:0]          ch_ext;
    logic [IDX_W-1:0]    idx;
    logic                ch_ok;

    logic [IR_W-1:0]     thr;
    logic [PERIOD_W-1:0] on_s;
    logic [PERIOD_W-1:0] full_s;
    logic [OFFSET_W-1:0] cfg_off;

    logic [TYPE_W-1:0]   eff_type;
    logic [TIME_W-1:0]   elapsed;
    logic [ON_MS_W-1:0]  on_ms;
    logic [ON_MS_W-1:0]  full_ms;
    logic [LIMIT_W-1:0]  full_lim;
    logic [LIMIT_W-1:0]  on_lim;
    logic [1:0]          lead_mask;
    logic [1:0]          trail_mask;

    logic                armed_next;
    logic                cycling_next;
    logic [TIME_W-1:0]   start_next;
    logic                lead_b_next;
    logic [OFFSET_W-1:0] offset_next;
    logic [1:0]          drive_next;

    assign ch_ext = {{(4-CH_W){1'b0}}, channel};
    assign idx    = ch_ext[IDX_W-1:0];
    assign ch_ok  = ch_ext < 4'(NUM_CHANNELS);

    // Per-channel fields of the packed registers; channels past the pack read 0
    always_comb begin
        thr     = '0;
        on_s    = '0;
        full_s  = '0;
        cfg_off = '0;
        case (channel)
            2'd0: begin
                thr     = cfg.thresholds[7:0];
                on_s    = cfg.on_periods[7:0];
                full_s  = cfg.full_periods[7:0];
                cfg_off = cfg.offsets[15:0];
            end
            2'd1: begin
                thr     = cfg.thresholds[15:8];
                on_s    = cfg.on_periods[15:8];
                full_s  = cfg.full_periods[15:8];
                cfg_off = cfg.offsets[31:16];
            end
            2'd2: begin
                thr     = cfg.thresholds[23:16];
                on_s    = cfg.on_periods[23:16];
                full_s  = cfg.full_periods[23:16];
                cfg_off = cfg.offsets[47:32];
            end
            default: ;
        endcase
    end

    // Limits and elapsed time
    assign on_ms    = ON_MS_W'(on_s) * ON_MS_W'(MS_PER_S);
    assign full_ms  = ON_MS_W'(full_s) * ON_MS_W'(MS_PER_S);
    assign full_lim = LIMIT_W'(full_ms) + LIMIT_W'(offset_reg[idx]);
    assign on_lim   = LIMIT_W'(on_ms) + LIMIT_W'(offset_reg[idx]);
    assign elapsed  = time_ms - start_reg[idx];
    assign eff_type = (requested_type == TYPE_RANDOM) ? TYPE_W'(random_type)
                                                       : requested_type;
    assign lead_mask  = lead_b_reg[idx] ? 2'b10 : 2'b01;
    assign trail_mask = lead_b_reg[idx] ? 2'b01 : 2'b10;

    // Next state of the addressed channel
    always_comb begin
        armed_next   = armed_reg[idx] | (ir_level > thr);
        cycling_next = cycling_reg[idx];
        start_next   = start_reg[idx];
        lead_b_next  = lead_b_reg[idx];
        offset_next  = offset_reg[idx];
        drive_next   = drive_reg[idx];
        if (armed_next) begin
            if (!cycling_reg[idx]) begin
                // Start of a cycle: latch the type and switch the leader on
                lead_b_next  = (eff_type == TYPE_STAGGER_B);
                offset_next  = ((eff_type == TYPE_STAGGER_A) ||
                                (eff_type == TYPE_STAGGER_B)) ? cfg_off : '0;
                cycling_next = 1'b1;
                start_next   = time_ms;
                drive_next   = drive_reg[idx] |
                               ((eff_type == TYPE_STAGGER_B) ? 2'b10 : 2'b01);
            end else if (elapsed > TIME_W'(full_lim)) begin
                cycling_next = 1'b0;
                armed_next   = 1'b0;
            end else if (elapsed > TIME_W'(on_lim)) begin
                drive_next = 2'b00;
            end else if (elapsed > TIME_W'(on_ms)) begin
                drive_next = drive_reg[idx] & ~lead_mask;
            end else if (elapsed > TIME_W'(offset_reg[idx])) begin
                drive_next = drive_reg[idx] | trail_mask;
            end
        end
    end

    assign drive_a = ch_ok & drive_next[0];
    assign drive_b = ch_ok & drive_next[1];

    // State write-back for in-range channels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                armed_reg[i]   <= 1'b0;
                cycling_reg[i] <= 1'b0;
                start_reg[i]   <= '0;
                lead_b_reg[i]  <= 1'b0;
                offset_reg[i]  <= '0;
                drive_reg[i]   <= '0;
            end
        end else if (step_en && ch_ok) begin
            armed_reg[idx]   <= armed_next;
            cycling_reg[idx] <= cycling_next;
            start_reg[idx]   <= start_next;
            lead_b_reg[idx]  <= lead_b_next;
            offset_reg[idx]  <= offset_next;
            drive_reg[idx]   <= drive_next;
        end
    end

endmodule : dacs_chan_core
`default_nettype wire

// File: design/dual_actuator_cycle_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// A request passes through the input register and one pass of channel logic
//   into the result register, which holds it until the receiver takes it.
// Throughput: one request per cycle while the result stream is not stalled; the per-channel
//   state is written back in the same cycle the result register loads, so requests follow back to back.
// Reset: synchronous, active low; clears all channel state, configuration registers and valids.
// ----------------------------------------------------------------------------
// dual_actuator_cycle_sequencer
// Streams per-channel IR updates and reports the two actuator drives.
// ----------------------------------------------------------------------------
module dual_actuator_cycle_sequencer
    import dacs_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Request stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [7:0] ir_level, [39:8] time_ms, [47:40] requested_type,
    // [49:48] random_type, [55:50] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] channel
    input  wire logic [CH_W-1:0]       s_tuser,
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] drive_a, [1] drive_b, [7:2] zero
    output logic [M_TDATA_W-1:0]       m_tdata,
    // [1:0] out_channel
    output logic [CH_W-1:0]            m_tuser
);

    cfg_regs_t         cfg;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CH_W-1:0]   ch_reg;
    logic [IR_W-1:0]   ir_reg;
    logic [TIME_W-1:0] time_reg;
    logic [TYPE_W-1:0] req_reg;
    logic [RND_W-1:0]  rnd_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CH_W-1:0]   out_ch_reg;
    logic              drive_a_reg;
    logic              drive_b_reg;

    logic              advance;
    logic              process;
    logic              s_accept;
    logic              drive_a;
    logic              drive_b;

    dacs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    dacs_chan_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (process),
        .channel        (ch_reg),
        .ir_level       (ir_reg),
        .time_ms        (time_reg),
        .requested_type (req_reg),
        .random_type    (rnd_reg),
        .cfg            (cfg),
        .drive_a        (drive_a),
        .drive_b        (drive_b)
    );

    // Pipeline flow control
    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (process ? 1'b0 : in_valid_reg);
    assign out_valid_next = process ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ch_reg   <= s_tuser;
            ir_reg   <= s_tdata[7:0];
            time_reg <= s_tdata[39:8];
            req_reg  <= s_tdata[47:40];
            rnd_reg  <= s_tdata[49:48];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (process) begin
            out_ch_reg  <= ch_reg;
            drive_a_reg <= drive_a;
            drive_b_reg <= drive_b;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ch_reg;
    assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, drive_b_reg, drive_a_reg};

    // Nothing is presented while in reset or just out of it
    a_no_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A request taken from the input register lands in the result register
    a_process_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> (m_tvalid && (m_tuser == $past(ch_reg))))
        else $error("processed request missing from result register");

    // Channels beyond the configured count report both drives off
    a_out_of_range_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ({2'b00, m_tuser} >= 4'(NUM_CHANNELS))) |-> (m_tdata[1:0] == 2'b00))
        else $error("drive reported for a channel that does not exist");

    // A stalled result with a full input register blocks new requests
    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("request accepted with no room in the pipeline");

endmodule : dual_actuator_cycle_sequencer
`default_nettype wire

// File: verif/tb_dual_actuator_cycle_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_actuator_cycle_sequencer
// Self-checking bench: streams channel updates through the sequencer under
// several register settings and idle patterns, predicts every drive report
// with a behavioral copy of the channel state, and compares in order.
// ----------------------------------------------------------------------------
module tb_dual_actuator_cycle_sequencer;
    import dacs_pkg::*;

    localparam int NUM_CH          = DEF_NUM_CHANNELS;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int HOLD_CYCLES     = 400;
    localparam int TIMEOUT_NS      = 2_000_000;

    // Index outside the register map, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;
    // Any type other than the staggered ones runs plain
    localparam logic [TYPE_W-1:0]    TYPE_PLAIN = 8'd0;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [IR_W-1:0]   ir;
        logic [TIME_W-1:0] now;
        logic [TYPE_W-1:0] req;
        logic [RND_W-1:0]  rnd;
    } update_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            drv_a;
        logic            drv_b;
    } drive_report_t;

    // DUT ports
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [CH_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [CH_W-1:0]       m_tuser;

    // Stimulus and scoreboard
    update_t       pending_updates[$];
    drive_report_t expected_drives[$];
    update_t       drv_item;
    update_t       seen_update;
    drive_report_t got_expect;
    int            items_queued   = 0;
    int            results_seen   = 0;
    int            mismatch_count = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            hold_seq       = 0;
    int            hold_seen      = 0;
    int            hold_left      = 0;
    logic [TIME_W-1:0] stim_now[4];
    int                step_limit[4];

    // Predicted block state
    logic [PACK8_W-1:0]  threshold_bytes;
    logic [PACK8_W-1:0]  on_bytes;
    logic [PACK8_W-1:0]  full_bytes;
    logic [PACK16_W-1:0] offset_words;
    logic                armed_q   [NUM_CH];
    logic                cycling_q [NUM_CH];
    logic [TIME_W-1:0]   start_q   [NUM_CH];
    logic                lead_b_q  [NUM_CH];
    logic [OFFSET_W-1:0] offs_q    [NUM_CH];
    logic [1:0]          drv_q     [NUM_CH];

    dual_actuator_cycle_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // One update of one channel: arm, start, or walk the cycle limits
    function automatic drive_report_t advance_channel(input update_t u);
        drive_report_t     r;
        int                c;
        logic [TYPE_W-1:0] kind;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] off_ms;
        logic [TIME_W-1:0] on_ms;
        logic [TIME_W-1:0] full_ms;
        logic [1:0]        lead_bit;
        logic [1:0]        trail_bit;
        c       = int'(u.ch);
        r.ch    = u.ch;
        r.drv_a = 1'b0;
        r.drv_b = 1'b0;
        if (c >= NUM_CH) return r;

        if (u.ir > threshold_bytes[c*PERIOD_W +: PERIOD_W]) armed_q[c] = 1'b1;

        if (armed_q[c]) begin
            if (!cycling_q[c]) begin
                kind = (u.req == TYPE_RANDOM) ? TYPE_W'(u.rnd) : u.req;
                if (kind == TYPE_STAGGER_A) begin
                    lead_b_q[c] = 1'b0;
                    offs_q[c]   = offset_words[c*OFFSET_W +: OFFSET_W];
                end else if (kind == TYPE_STAGGER_B) begin
                    lead_b_q[c] = 1'b1;
                    offs_q[c]   = offset_words[c*OFFSET_W +: OFFSET_W];
                end else begin
                    lead_b_q[c] = 1'b0;
                    offs_q[c]   = '0;
                end
                cycling_q[c] = 1'b1;
                start_q[c]   = u.now;
                drv_q[c]     = drv_q[c] | (lead_b_q[c] ? 2'b10 : 2'b01);
            end else begin
                elapsed   = u.now - start_q[c];
                off_ms    = TIME_W'(offs_q[c]);
                on_ms     = TIME_W'(on_bytes[c*PERIOD_W +: PERIOD_W]) * MS_PER_S;
                full_ms   = TIME_W'(full_bytes[c*PERIOD_W +: PERIOD_W]) * MS_PER_S;
                lead_bit  = lead_b_q[c] ? 2'b10 : 2'b01;
                trail_bit = lead_b_q[c] ? 2'b01 : 2'b10;
                // First limit exceeded wins; ties do not count
                if (elapsed > full_ms + off_ms) begin
                    cycling_q[c] = 1'b0;
                    armed_q[c]   = 1'b0;
                end else if (elapsed > on_ms + off_ms) begin
                    drv_q[c] = 2'b00;
                end else if (elapsed > on_ms) begin
                    drv_q[c] = drv_q[c] & ~lead_bit;
                end else if (elapsed > off_ms) begin
                    drv_q[c] = drv_q[c] | trail_bit;
                end
            end
        end
        r.drv_a = drv_q[c][0];
        r.drv_b = drv_q[c][1];
        return r;
    endfunction

    // Predictor: track register writes and accepted requests
    always @(posedge aclk) begin
        if (!aresetn) begin
            threshold_bytes = '0;
            on_bytes        = '0;
            full_bytes      = '0;
            offset_words    = '0;
            for (int i = 0; i < NUM_CH; i++) begin
                armed_q[i]   = 1'b0;
                cycling_q[i] = 1'b0;
                start_q[i]   = '0;
                lead_b_q[i]  = 1'b0;
                offs_q[i]    = '0;
                drv_q[i]     = 2'b00;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_THRESHOLDS:   threshold_bytes = cfg_data[PACK8_W-1:0];
                    CFG_ON_PERIODS:   on_bytes        = cfg_data[PACK8_W-1:0];
                    CFG_FULL_PERIODS: full_bytes      = cfg_data[PACK8_W-1:0];
                    CFG_OFFSETS:      offset_words    = cfg_data[PACK16_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                seen_update.ch  = s_tuser;
                seen_update.ir  = s_tdata[7:0];
                seen_update.now = s_tdata[39:8];
                seen_update.req = s_tdata[47:40];
                seen_update.rnd = s_tdata[49:48];
                expected_drives.push_back(advance_channel(seen_update));
            end
        end
    end

    // Request driver: hold each request until taken, idle at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_updates.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_item = pending_updates.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'd0, drv_item.rnd, drv_item.req, drv_item.now, drv_item.ir};
                s_tuser  <= drv_item.ch;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_drives.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result ch %0d data %0h", $time, m_tuser, m_tdata);
                end else begin
                    got_expect = expected_drives.pop_front();
                    if (m_tuser !== got_expect.ch) begin
                        mismatch_count++;
                        $display("%0t: out_channel expected %0d actual %0d",
                                 $time, got_expect.ch, m_tuser);
                    end
                    if (m_tdata[0] !== got_expect.drv_a) begin
                        mismatch_count++;
                        $display("%0t: ch %0d drive_a expected %0d actual %0d",
                                 $time, got_expect.ch, got_expect.drv_a, m_tdata[0]);
                    end
                    if (m_tdata[1] !== got_expect.drv_b) begin
                        mismatch_count++;
                        $display("%0t: ch %0d drive_b expected %0d actual %0d",
                                 $time, got_expect.ch, got_expect.drv_b, m_tdata[1]);
                    end
                end
            end
            // Long hold-off on request, otherwise random stalls
            if (hold_seq != hold_seen) begin
                hold_seen <= hold_seq;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Write all four registers and size the random time steps to the cycle
    task automatic program_registers(input logic [PACK8_W-1:0]  thr,
                                     input logic [PACK8_W-1:0]  on_s,
                                     input logic [PACK8_W-1:0]  full_s,
                                     input logic [PACK16_W-1:0] offs);
        write_reg(CFG_THRESHOLDS, CFG_DATA_W'(thr));
        write_reg(CFG_ON_PERIODS, CFG_DATA_W'(on_s));
        write_reg(CFG_FULL_PERIODS, CFG_DATA_W'(full_s));
        write_reg(CFG_OFFSETS, CFG_DATA_W'(offs));
        for (int c = 0; c < NUM_CH; c++) begin
            step_limit[c] = (int'(full_s[c*PERIOD_W +: PERIOD_W]) * MS_PER_S
                             + int'(offs[c*OFFSET_W +: OFFSET_W])) / 5 + 20;
            stim_now[c]   = $urandom();
        end
    endtask

    // Short periods so that cycles run through all their states
    task automatic program_random_registers();
        logic [PACK8_W-1:0]  thr;
        logic [PACK8_W-1:0]  on_s;
        logic [PACK8_W-1:0]  full_s;
        logic [PACK16_W-1:0] offs;
        int                  onb;
        for (int c = 0; c < NUM_CH; c++) begin
            onb = $urandom_range(0, 4);
            thr[c*PERIOD_W +: PERIOD_W]    = PERIOD_W'($urandom_range(0, 255));
            on_s[c*PERIOD_W +: PERIOD_W]   = PERIOD_W'(onb);
            full_s[c*PERIOD_W +: PERIOD_W] = PERIOD_W'(($urandom_range(0, 3) == 0) ?
                                             $urandom_range(0, 4) : onb + $urandom_range(1, 3));
            offs[c*OFFSET_W +: OFFSET_W]   = OFFSET_W'($urandom_range(0, 2500));
        end
        program_registers(thr, on_s, full_s, offs);
    endtask

    task automatic queue_update(input logic [CH_W-1:0] ch, input logic [IR_W-1:0] ir,
                                input logic [TIME_W-1:0] now, input logic [TYPE_W-1:0] req,
                                input logic [RND_W-1:0] rnd);
        update_t u;
        u.ch  = ch;
        u.ir  = ir;
        u.now = now;
        u.req = req;
        u.rnd = rnd;
        pending_updates.push_back(u);
        items_queued++;
    endtask

    // Mostly per-channel advancing time; a few fully random updates
    task automatic queue_random_updates(input int count);
        logic [CH_W-1:0]   ch;
        logic [TYPE_W-1:0] req;
        logic [RND_W-1:0]  rnd;
        for (int k = 0; k < count; k++) begin
            ch  = ($urandom_range(0, 29) == 0) ? 2'd3 : CH_W'($urandom_range(0, NUM_CH - 1));
            rnd = ($urandom_range(0, 7) == 0) ? 2'd3 : RND_W'($urandom_range(0, 2));
            if ($urandom_range(0, 24) == 0) begin
                queue_update(ch, IR_W'($urandom_range(0, 255)), $urandom(),
                             TYPE_W'($urandom_range(0, 255)), RND_W'($urandom_range(0, 3)));
            end else begin
                stim_now[ch] = stim_now[ch] + $urandom_range(0, step_limit[ch]);
                case ($urandom_range(0, 5))
                    0:       req = TYPE_STAGGER_A;
                    1:       req = TYPE_STAGGER_B;
                    2, 3:    req = TYPE_RANDOM;
                    4:       req = TYPE_PLAIN;
                    default: req = TYPE_W'($urandom_range(0, 255));
                endcase
                queue_update(ch, IR_W'($urandom_range(0, 255)), stim_now[ch], req, rnd);
            end
        end
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued) @(posedge aclk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Run timeout
    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Main sequence
    initial begin
        stim_now[3]   = '0;
        step_limit[3] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: ch0 staggered a-lead 1 s on, 2 s full, 500 ms offset;
        // ch1 zero threshold, zero periods, max offset; ch2 never arms
        program_registers(24'hFF0064, 24'hFF0001, 24'h000002, 48'h0000_FFFF_01F4);
        write_reg(CFG_UNUSED, '1);
        queue_update(2'd0, 8'd0,   32'd0,    TYPE_STAGGER_A, 2'd0); // below threshold
        queue_update(2'd0, 8'd100, 32'd10,   TYPE_STAGGER_A, 2'd0); // equal, no arm
        queue_update(2'd0, 8'd101, 32'd1000, TYPE_STAGGER_A, 2'd0); // start, a leads
        queue_update(2'd0, 8'd0,   32'd1500, TYPE_PLAIN, 2'd0);     // at offset
        queue_update(2'd0, 8'd0,   32'd1501, TYPE_PLAIN, 2'd0);     // trailing on
        queue_update(2'd0, 8'd0,   32'd2000, TYPE_PLAIN, 2'd0);     // at on period
        queue_update(2'd0, 8'd0,   32'd2001, TYPE_PLAIN, 2'd0);     // leading off
        queue_update(2'd0, 8'd0,   32'd2501, TYPE_PLAIN, 2'd0);     // both off
        queue_update(2'd0, 8'd0,   32'd3500, TYPE_PLAIN, 2'd0);     // at full period
        queue_update(2'd0, 8'd0,   32'd3501, TYPE_PLAIN, 2'd0);     // cycle ends
        queue_update(2'd0, 8'd0,   32'd3600, TYPE_PLAIN, 2'd0);     // disarmed
        // ch1: random type picks b-lead, elapsed wraps through zero
        queue_update(2'd1, 8'd1,   32'hFFFF_FF00, TYPE_RANDOM, 2'd2);
        queue_update(2'd1, 8'd0,   32'h0000_0100, TYPE_RANDOM, 2'd3);
        queue_update(2'd1, 8'd0,   32'h0001_0000, TYPE_PLAIN, 2'd0);
        // random type out of range runs plain, no offset
        queue_update(2'd1, 8'd255, 32'hFFFF_FFFF, TYPE_RANDOM, 2'd3);
        queue_update(2'd1, 8'd0,   32'd0,         TYPE_PLAIN, 2'd1);
        queue_update(2'd1, 8'd7,   32'd5,         8'd254, 2'd1);
        queue_update(2'd2, 8'd255, 32'hAAAA_5555, TYPE_STAGGER_B, 2'd0); // max threshold
        // channel out of range
        queue_update(2'd3, 8'd255, 32'hFFFF_FFFF, TYPE_STAGGER_A, 2'd1);
        queue_update(2'd3, 8'd0,   32'd0,         TYPE_PLAIN, 2'd0);
        queue_update(2'd0, 8'd255, 32'h5555_AAAA, TYPE_RANDOM, 2'd1);
        queue_update(2'd0, 8'd200, 32'h5555_AAAA, TYPE_RANDOM, 2'd0); // zero elapsed
        queue_update(2'd1, 8'd128, 32'd6,         8'd128, 2'd0);
        wait_drained();

        // No idling; receiver holds off long enough to back up the input
        program_random_registers();
        hold_seq <= hold_seq + 1;
        queue_random_updates(ITEMS_PER_PHASE);
        wait_drained();

        program_random_registers();
        set_idling(86, 0);
        queue_random_updates(ITEMS_PER_PHASE);
        wait_drained();

        program_random_registers();
        set_idling(0, 86);
        queue_random_updates(ITEMS_PER_PHASE);
        wait_drained();

        program_random_registers();
        set_idling(36, 36);
        queue_random_updates(ITEMS_PER_PHASE);
        wait_drained();

        // All registers zero: a started cycle ends on its next update with nonzero elapsed time
        program_registers('0, '0, '0, '0);
        set_idling(0, 0);
        queue_random_updates(200);
        wait_drained();

        // Longest periods and offsets
        program_registers(24'h008000, '1, '1, '1);
        set_idling(36, 36);
        queue_random_updates(ITEMS_PER_PHASE);
        wait_drained();

        // Max thresholds: nothing new arms
        write_reg(CFG_THRESHOLDS, CFG_DATA_W'(24'hFFFFFF));
        queue_random_updates(40);
        wait_drained();

        repeat (4) @(posedge aclk);
        if (expected_drives.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_drives.size());
        end
        if (mismatch_count == 0 && expected_drives.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
